FILE: hdl/bgpfsm_pkg.sv
// Shared types and constants for the BGP peer session state machine.
`default_nettype none

package bgpfsm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_CONNECT     = 3'd1,
    ST_ACTIVE      = 3'd2,
    ST_OPENSENT    = 3'd3,
    ST_OPENCONFIRM = 3'd4,
    ST_ESTABLISHED = 3'd5
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_OPEN      = 3'd1,
    ACT_KEEPALIVE = 3'd2,
    ACT_NOTIFY    = 3'd3,
    ACT_CONNECT   = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    KIND_OPEN      = 4'd0,
    KIND_KEEPALIVE = 4'd1,
    KIND_NOTIFY    = 4'd2,
    KIND_UPDATE    = 4'd3,
    KIND_TCP_EXC   = 4'd4,
    KIND_TIMER     = 4'd5,
    KIND_START     = 4'd6,
    KIND_STOP      = 4'd7,
    KIND_CONNECT   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_AS  = 2'd0,
    CFG_HOLD_TIME = 2'd1,
    CFG_ROUTER_ID = 2'd2
  } cfg_idx_e;

  // sub_event codes
  localparam logic [1:0] TCP_CLOSE       = 2'd0;
  localparam logic [1:0] TCP_RETX_TMO    = 2'd2;
  localparam logic [1:0] TMR_CONN_RETRY  = 2'd0;
  localparam logic [1:0] TMR_HOLD        = 2'd1;
  localparam logic [1:0] TMR_KEEPALIVE   = 2'd2;
  localparam logic [1:0] SUB_EV_INVALID  = 2'd3;

  // notification error codes and subcodes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_HEADER       = 3'd1;
  localparam logic [2:0] ERR_OPEN         = 3'd2;
  localparam logic [2:0] ERR_HOLD_EXPIRED = 3'd4;
  localparam logic [2:0] SUB_NONE         = 3'd0;
  localparam logic [2:0] SUB_VERSION      = 3'd1;
  localparam logic [2:0] SUB_BAD_LEN      = 3'd2;
  localparam logic [2:0] SUB_HOLD_TIME    = 3'd6;

  localparam logic [15:0] MIN_MSG_LEN   = 16'd19;
  localparam logic [15:0] MAX_MSG_LEN   = 16'd4096;
  localparam logic [7:0]  OPEN_VERSION  = 8'd4;
  localparam logic [15:0] HOLD_BAD_ONE  = 16'd1;
  localparam logic [15:0] HOLD_BAD_TWO  = 16'd2;
  localparam logic [15:0] HOLD_TIME_RST = 16'd180;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] msg_length;
    logic [7:0]  peer_version;
    logic [15:0] peer_hold_time;
    logic [1:0]  sub_event;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  next_state;
    logic        status;
    logic [2:0]  action;
    logic [2:0]  notify_error;
    logic [2:0]  notify_subcode;
    logic [15:0] open_as_number;
    logic [15:0] open_hold_time;
    logic [31:0] open_router_id;
  } out_item_t;

  typedef struct packed {
    logic [15:0] as_number;
    logic [15:0] hold_time;
    logic [31:0] router_id;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/bgp_peer_session_fsm_top.sv
// BGP peer session state machine: events in, next state and one action out.
// Each accepted event is registered in an input register, evaluated against
// the session state and written to an output register, from which its result
// is offered. One event is taken every cycle while the output side does not
// stall; the figure is set by the update of the 3-bit session state, which
// happens as an event moves into the output register. A stall on the output
// side holds the result and backs up into in_stall_o in the same cycle once
// the input register is also full. Configuration registers take effect for
// events evaluated after the write and should be written while no event is
// in flight.
`default_nettype none

module bgp_peer_session_fsm_top import bgpfsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o
);

  cfg_t      cfg;
  out_item_t result;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      advance, in_accept;

  bgpfsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgpfsm_session u_session (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_item_q <= in_item_i;
    if (advance) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: hdl/bgpfsm_cfg_regs.sv
// Configuration registers: local AS, proposed hold time, router id.
`default_nettype none

module bgpfsm_cfg_regs import bgpfsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOCAL_AS:  cfg_d.as_number = cfg_wdata_i[15:0];
        CFG_HOLD_TIME: cfg_d.hold_time = cfg_wdata_i[15:0];
        CFG_ROUTER_ID: cfg_d.router_id = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.as_number <= '0;
      cfg_q.hold_time <= HOLD_TIME_RST;
      cfg_q.router_id <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/bgpfsm_session.sv
// Session state register and per-event transition and action logic.
`default_nettype none

module bgpfsm_session import bgpfsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  state_e  state_q, state_d, nxt;
  action_e act;
  logic    status;
  logic [2:0] err, sub;
  logic [1:0] ev;
  logic    len_bad, ver_bad, hold_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ev       = item_i.sub_event;
    len_bad  = (item_i.msg_length < MIN_MSG_LEN) || (item_i.msg_length > MAX_MSG_LEN);
    ver_bad  = (item_i.peer_version != OPEN_VERSION);
    hold_bad = (item_i.peer_hold_time == HOLD_BAD_ONE) ||
               (item_i.peer_hold_time == HOLD_BAD_TWO);
    nxt    = state_q;
    act    = ACT_NONE;
    status = STATUS_OK;
    err    = ERR_NONE;
    sub    = SUB_NONE;

    unique case (kind_e'(item_i.kind))
      KIND_OPEN: begin
        // checks in priority order: length, version, hold time
        if (len_bad) begin
          err = ERR_HEADER;
          sub = SUB_BAD_LEN;
        end else if (ver_bad) begin
          err = ERR_OPEN;
          sub = SUB_VERSION;
        end else if (hold_bad) begin
          err = ERR_OPEN;
          sub = SUB_HOLD_TIME;
        end
        if (len_bad || ver_bad || hold_bad) begin
          status = STATUS_REJECTED;
          nxt    = ST_IDLE;
          act    = ACT_NOTIFY;
        end else if (state_q == ST_OPENSENT) begin
          nxt = ST_OPENCONFIRM;
          act = ACT_KEEPALIVE;
        end else begin
          nxt = ST_IDLE;
        end
      end
      KIND_KEEPALIVE: begin
        if (state_q == ST_OPENCONFIRM) begin
          nxt = ST_ESTABLISHED;
        end else if (state_q == ST_ESTABLISHED) begin
          act = ACT_KEEPALIVE;
        end else begin
          nxt = ST_IDLE;
        end
      end
      KIND_NOTIFY: nxt = ST_IDLE;
      KIND_UPDATE: begin
        if (state_q != ST_ESTABLISHED) nxt = ST_IDLE;
      end
      KIND_TCP_EXC: begin
        if (ev != SUB_EV_INVALID) begin
          unique case (state_q)
            ST_CONNECT:     nxt = (ev == TCP_RETX_TMO) ? ST_ACTIVE : ST_IDLE;
            ST_ACTIVE: begin
              if (ev != TCP_RETX_TMO) nxt = ST_IDLE;
            end
            ST_OPENSENT:    nxt = (ev == TCP_CLOSE) ? ST_ACTIVE : ST_IDLE;
            ST_OPENCONFIRM: nxt = ST_IDLE;
            ST_ESTABLISHED: nxt = ST_IDLE;
            default: ;
          endcase
        end
      end
      KIND_TIMER: begin
        if (ev != SUB_EV_INVALID) begin
          unique case (state_q)
            ST_CONNECT: begin
              if (ev != TMR_CONN_RETRY) nxt = ST_IDLE;
            end
            ST_ACTIVE: begin
              if (ev == TMR_CONN_RETRY) begin
                nxt = ST_CONNECT;
                act = ACT_CONNECT;
              end else begin
                nxt = ST_IDLE;
              end
            end
            ST_OPENSENT: nxt = ST_IDLE;
            ST_OPENCONFIRM: begin
              if (ev == TMR_KEEPALIVE) begin
                act = ACT_KEEPALIVE;
              end else begin
                nxt = ST_IDLE;
                if (ev == TMR_HOLD) begin
                  err = ERR_HOLD_EXPIRED;
                  act = ACT_NOTIFY;
                end
              end
            end
            ST_ESTABLISHED: begin
              if (ev == TMR_KEEPALIVE) act = ACT_KEEPALIVE;
              else nxt = ST_IDLE;
            end
            default: ;
          endcase
        end
      end
      KIND_START: begin
        // an out-of-range state code behaves like idle
        if (state_q == ST_IDLE || state_q > ST_ESTABLISHED) begin
          nxt = ST_CONNECT;
          act = ACT_CONNECT;
        end
      end
      KIND_STOP: nxt = ST_IDLE;
      KIND_CONNECT: begin
        if (state_q == ST_CONNECT || state_q == ST_ACTIVE) begin
          nxt = ST_OPENSENT;
          act = ACT_OPEN;
        end else begin
          nxt = ST_IDLE;
        end
      end
      default: ;
    endcase

    state_d = adv_i ? nxt : state_q;

    result_o.next_state     = nxt;
    result_o.status         = status;
    result_o.action         = act;
    result_o.notify_error   = (act == ACT_NOTIFY) ? err : ERR_NONE;
    result_o.notify_subcode = (act == ACT_NOTIFY) ? sub : SUB_NONE;
    result_o.open_as_number = (act == ACT_OPEN) ? cfg_i.as_number : '0;
    result_o.open_hold_time = (act == ACT_OPEN) ? cfg_i.hold_time : '0;
    result_o.open_router_id = (act == ACT_OPEN) ? cfg_i.router_id : '0;
  end

endmodule

`default_nettype wire

FILE: hdl/bgpfsm_checker.sv
// Port-level checks for the BGP session state machine and their bind.
`default_nettype none

module bgpfsm_checker import bgpfsm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [1:0]  cfg_index_i,
  input wire logic [31:0] cfg_wdata_i,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input in_item_t         in_item_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input out_item_t        out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_open_to_opensent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.action == ACT_OPEN |-> out_item_o.next_state == ST_OPENSENT)
    else $error("send OPEN without move to opensent");

  a_reject_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_REJECTED |->
      out_item_o.action == ACT_NOTIFY && out_item_o.next_state == ST_IDLE)
    else $error("rejected OPEN without notification to idle");

  a_notify_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.action != ACT_NOTIFY |->
      out_item_o.notify_error == ERR_NONE && out_item_o.notify_subcode == SUB_NONE)
    else $error("notification fields set without notification");

  // unused here but part of the port view
  logic unused_ok;
  assign unused_ok = ^{cfg_we_i, cfg_index_i, cfg_wdata_i, in_valid_i, in_stall_o, in_item_i};

endmodule

bind bgp_peer_session_fsm_top bgpfsm_checker u_bgpfsm_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for bgp_peer_session_fsm_top: directed and random event traffic checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import bgpfsm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [3:0] KIND_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;
  localparam logic [1:0] TCP_FATAL = 2'd1;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  // predictor copy of the session and the OPEN parameters
  state_e session_q = ST_IDLE;
  cfg_t local_cfg = '{as_number: 16'd0, hold_time: HOLD_TIME_RST, router_id: 32'd0};

  out_item_t expected_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;

  bgp_peer_session_fsm_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Next session state and transport action for one event.
  function automatic out_item_t predict_event(in_item_t ev);
    state_e cur;
    action_e act;
    logic rejected;
    logic [2:0] err;
    logic [2:0] sub;
    out_item_t res;
    cur = session_q;
    act = ACT_NONE;
    rejected = STATUS_OK;
    err = ERR_NONE;
    sub = SUB_NONE;
    case (ev.kind) inside
      KIND_OPEN: begin
        if (ev.msg_length < MIN_MSG_LEN || ev.msg_length > MAX_MSG_LEN) begin
          err = ERR_HEADER;
          sub = SUB_BAD_LEN;
        end else if (ev.peer_version != OPEN_VERSION) begin
          err = ERR_OPEN;
          sub = SUB_VERSION;
        end else if (ev.peer_hold_time == HOLD_BAD_ONE || ev.peer_hold_time == HOLD_BAD_TWO) begin
          err = ERR_OPEN;
          sub = SUB_HOLD_TIME;
        end
        if (err != ERR_NONE) begin
          rejected = STATUS_REJECTED;
          act = ACT_NOTIFY;
          session_q = ST_IDLE;
        end else if (cur == ST_OPENSENT) begin
          session_q = ST_OPENCONFIRM;
          act = ACT_KEEPALIVE;
        end else begin
          session_q = ST_IDLE;
        end
      end
      KIND_KEEPALIVE: begin
        if (cur == ST_OPENCONFIRM) session_q = ST_ESTABLISHED;
        else if (cur == ST_ESTABLISHED) act = ACT_KEEPALIVE;
        else session_q = ST_IDLE;
      end
      KIND_NOTIFY, KIND_STOP: session_q = ST_IDLE;
      KIND_UPDATE: begin
        if (cur != ST_ESTABLISHED) session_q = ST_IDLE;
      end
      KIND_TCP_EXC: begin
        if (ev.sub_event != SUB_EV_INVALID) begin
          case (cur) inside
            ST_CONNECT: session_q = (ev.sub_event == TCP_RETX_TMO) ? ST_ACTIVE : ST_IDLE;
            ST_ACTIVE: begin
              if (ev.sub_event != TCP_RETX_TMO) session_q = ST_IDLE;
            end
            ST_OPENSENT: session_q = (ev.sub_event == TCP_CLOSE) ? ST_ACTIVE : ST_IDLE;
            ST_OPENCONFIRM, ST_ESTABLISHED: session_q = ST_IDLE;
            default: ;
          endcase
        end
      end
      KIND_TIMER: begin
        if (ev.sub_event != SUB_EV_INVALID) begin
          case (cur)
            ST_CONNECT: begin
              if (ev.sub_event != TMR_CONN_RETRY) session_q = ST_IDLE;
            end
            ST_ACTIVE: begin
              if (ev.sub_event == TMR_CONN_RETRY) begin
                session_q = ST_CONNECT;
                act = ACT_CONNECT;
              end else begin
                session_q = ST_IDLE;
              end
            end
            ST_OPENSENT: session_q = ST_IDLE;
            ST_OPENCONFIRM: begin
              if (ev.sub_event == TMR_KEEPALIVE) begin
                act = ACT_KEEPALIVE;
              end else begin
                session_q = ST_IDLE;
                if (ev.sub_event == TMR_HOLD) begin
                  err = ERR_HOLD_EXPIRED;
                  act = ACT_NOTIFY;
                end
              end
            end
            ST_ESTABLISHED: begin
              if (ev.sub_event == TMR_KEEPALIVE) act = ACT_KEEPALIVE;
              else session_q = ST_IDLE;
            end
            default: ;
          endcase
        end
      end
      KIND_START: begin
        // an out-of-range state code behaves like idle
        if (cur == ST_IDLE || cur > ST_ESTABLISHED) begin
          session_q = ST_CONNECT;
          act = ACT_CONNECT;
        end
      end
      KIND_CONNECT: begin
        if (cur == ST_CONNECT || cur == ST_ACTIVE) begin
          session_q = ST_OPENSENT;
          act = ACT_OPEN;
        end else begin
          session_q = ST_IDLE;
        end
      end
      default: ;
    endcase
    res = '0;
    res.next_state = session_q;
    res.status = rejected;
    res.action = act;
    if (act == ACT_NOTIFY) begin
      res.notify_error = err;
      res.notify_subcode = sub;
    end
    if (act == ACT_OPEN) begin
      res.open_as_number = local_cfg.as_number;
      res.open_hold_time = local_cfg.hold_time;
      res.open_router_id = local_cfg.router_id;
    end
    return res;
  endfunction

  function automatic in_item_t make_event(logic [3:0] kind, logic [15:0] len, logic [7:0] ver,
                                          logic [15:0] hold, logic [1:0] sub);
    in_item_t ev;
    ev.kind = kind;
    ev.msg_length = len;
    ev.peer_version = ver;
    ev.peer_hold_time = hold;
    ev.sub_event = sub;
    return ev;
  endfunction

  function automatic logic [15:0] acceptable_hold();
    logic [15:0] hold;
    hold = 16'($urandom);
    if (hold == HOLD_BAD_ONE || hold == HOLD_BAD_TWO) hold = 16'd0;
    return hold;
  endfunction

  // Mostly events that move the session forward from its current state, with noise mixed in.
  function automatic in_item_t session_event();
    in_item_t ev;
    ev = make_event(4'($urandom_range(0, 15)), 16'($urandom), 8'($urandom), 16'($urandom),
                    2'($urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 12) begin
      if (ev.kind == KIND_OPEN) begin
        case ($urandom_range(0, 3))
          0: ev.msg_length = 16'($urandom_range(0, 18));
          1: ev.msg_length = 16'($urandom_range(MIN_MSG_LEN, MAX_MSG_LEN));
          2: begin
            ev.msg_length = 16'($urandom_range(MIN_MSG_LEN, MAX_MSG_LEN));
            ev.peer_version = OPEN_VERSION;
            ev.peer_hold_time = 16'($urandom_range(HOLD_BAD_ONE, HOLD_BAD_TWO));
          end
          default: ;
        endcase
      end
      return ev;
    end
    case (session_q)
      ST_IDLE: ev.kind = KIND_START;
      ST_CONNECT: begin
        case ($urandom_range(0, 5))
          0: begin
            ev.kind = KIND_TCP_EXC;
            ev.sub_event = TCP_RETX_TMO;
          end
          1: begin
            ev.kind = KIND_TIMER;
            ev.sub_event = TMR_CONN_RETRY;
          end
          default: ev.kind = KIND_CONNECT;
        endcase
      end
      ST_ACTIVE: begin
        if ($urandom_range(0, 2) == 0) begin
          ev.kind = KIND_TIMER;
          ev.sub_event = TMR_CONN_RETRY;
        end else begin
          ev.kind = KIND_CONNECT;
        end
      end
      ST_OPENSENT: begin
        ev.kind = KIND_OPEN;
        ev.msg_length = 16'($urandom_range(MIN_MSG_LEN, MAX_MSG_LEN));
        ev.peer_version = OPEN_VERSION;
        ev.peer_hold_time = acceptable_hold();
      end
      ST_OPENCONFIRM: begin
        if ($urandom_range(0, 3) == 0) begin
          ev.kind = KIND_TIMER;
          ev.sub_event = TMR_KEEPALIVE;
        end else begin
          ev.kind = KIND_KEEPALIVE;
        end
      end
      default: begin
        case ($urandom_range(0, 5))
          0, 1, 2: ev.kind = KIND_UPDATE;
          3: ev.kind = KIND_KEEPALIVE;
          default: begin
            ev.kind = KIND_TIMER;
            ev.sub_event = TMR_KEEPALIVE;
          end
        endcase
      end
    endcase
    return ev;
  endfunction

  task automatic send_event(in_item_t ev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_event(ev));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_LOCAL_AS:  local_cfg.as_number = data[15:0];
      CFG_HOLD_TIME: local_cfg.hold_time = data[15:0];
      CFG_ROUTER_ID: local_cfg.router_id = data;
      default: ;
    endcase
  endtask

  // Upper bits of the 16-bit registers carry junk; the spare index must be ignored.
  task automatic program_regs(logic [15:0] as_num, logic [15:0] hold, logic [31:0] rid);
    wait_for_results();
    write_reg(CFG_SPARE_IDX, $urandom);
    write_reg(CFG_LOCAL_AS, {16'($urandom), as_num});
    write_reg(CFG_HOLD_TIME, {16'($urandom), hold});
    write_reg(CFG_ROUTER_ID, rid);
    cfg_we <= 1'b0;
  endtask

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t exp;
    string bad;
    if (expected_q.size() == 0) begin
      note_mismatch("result with no event outstanding");
      return;
    end
    exp = expected_q.pop_front();
    bad = "";
    if (got.next_state !== exp.next_state) bad = {bad, " next_state"};
    if (got.status !== exp.status) bad = {bad, " status"};
    if (got.action !== exp.action) bad = {bad, " action"};
    if (got.notify_error !== exp.notify_error) bad = {bad, " notify_error"};
    if (got.notify_subcode !== exp.notify_subcode) bad = {bad, " notify_subcode"};
    if (got.open_as_number !== exp.open_as_number) bad = {bad, " open_as_number"};
    if (got.open_hold_time !== exp.open_hold_time) bad = {bad, " open_hold_time"};
    if (got.open_router_id !== exp.open_router_id) bad = {bad, " open_router_id"};
    if (bad != "")
      note_mismatch($sformatf({"mismatch in", bad, ": exp st %0d stat %0d act %0d err %0d sub %0d",
                               " as %h hold %h id %h / got st %0d stat %0d act %0d err %0d",
                               " sub %0d as %h hold %h id %h"},
                              exp.next_state, exp.status, exp.action, exp.notify_error,
                              exp.notify_subcode, exp.open_as_number, exp.open_hold_time,
                              exp.open_router_id, got.next_state, got.status, got.action,
                              got.notify_error, got.notify_subcode, got.open_as_number,
                              got.open_hold_time, got.open_router_id));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
  end

  // receiver backpressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // OPEN sent with the register values left by reset
  task automatic test_reset_config();
    send_event(make_event(KIND_START, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_CONNECT, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_STOP, 16'hFFFF, 8'hFF, 16'hFFFF, 2'd3));
  endtask

  task automatic test_open_validation();
    send_event(make_event(KIND_OPEN, 16'd18, OPEN_VERSION, 16'd90, 2'd0));
    send_event(make_event(KIND_OPEN, 16'd4097, OPEN_VERSION, 16'd90, 2'd0));
    // bad length wins over bad version and bad hold time
    send_event(make_event(KIND_OPEN, 16'd0, 8'd0, HOLD_BAD_ONE, 2'd0));
    send_event(make_event(KIND_OPEN, 16'hFFFF, 8'hFF, 16'hFFFF, 2'd3));
    send_event(make_event(KIND_OPEN, MIN_MSG_LEN, 8'd3, HOLD_BAD_TWO, 2'd0));
    send_event(make_event(KIND_OPEN, MAX_MSG_LEN, 8'hFF, 16'd90, 2'd0));
    send_event(make_event(KIND_OPEN, MIN_MSG_LEN, OPEN_VERSION, HOLD_BAD_ONE, 2'd0));
    send_event(make_event(KIND_OPEN, MAX_MSG_LEN, OPEN_VERSION, HOLD_BAD_TWO, 2'd0));
    // well-formed OPEN outside opensent drops to idle
    send_event(make_event(KIND_OPEN, MIN_MSG_LEN, OPEN_VERSION, 16'd0, 2'd0));
    send_event(make_event(KIND_OPEN, MAX_MSG_LEN, OPEN_VERSION, 16'hFFFF, 2'd0));
  endtask

  task automatic test_state_transitions();
    send_event(make_event(KIND_CONNECT, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_START, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_TCP_EXC, 16'd0, 8'd0, 16'd0, TCP_RETX_TMO));
    send_event(make_event(KIND_TIMER, 16'd0, 8'd0, 16'd0, TMR_CONN_RETRY));
    send_event(make_event(KIND_CONNECT, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_OPEN, MIN_MSG_LEN, OPEN_VERSION, 16'd3, 2'd0));
    send_event(make_event(KIND_TIMER, 16'd0, 8'd0, 16'd0, TMR_KEEPALIVE));
    send_event(make_event(KIND_KEEPALIVE, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_KEEPALIVE, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_UPDATE, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_TCP_EXC, 16'd0, 8'd0, 16'd0, SUB_EV_INVALID));
    send_event(make_event(KIND_TIMER, 16'd0, 8'd0, 16'd0, SUB_EV_INVALID));
    send_event(make_event(KIND_UNKNOWN_LO, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_UNKNOWN_HI, 16'hFFFF, 8'hFF, 16'hFFFF, 2'd3));
    send_event(make_event(KIND_TIMER, 16'd0, 8'd0, 16'd0, TMR_HOLD));
    // hold timer in openconfirm sends a notification
    send_event(make_event(KIND_START, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_CONNECT, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_TCP_EXC, 16'd0, 8'd0, 16'd0, TCP_CLOSE));
    send_event(make_event(KIND_CONNECT, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_OPEN, MAX_MSG_LEN, OPEN_VERSION, 16'd180, 2'd0));
    send_event(make_event(KIND_TIMER, 16'd0, 8'd0, 16'd0, TMR_HOLD));
    send_event(make_event(KIND_START, 16'd0, 8'd0, 16'd0, 2'd0));
    send_event(make_event(KIND_TCP_EXC, 16'd0, 8'd0, 16'd0, TCP_FATAL));
    send_event(make_event(KIND_NOTIFY, 16'd0, 8'd0, 16'd0, 2'd0));
  endtask

  task automatic test_random_sessions(int unsigned n);
    repeat (n) send_event(session_event());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_open_validation();
    test_state_transitions();

    program_regs(16'd0, 16'd0, 32'd0);
    test_random_sessions(300);
    program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    test_random_sessions(300);
    program_regs(16'($urandom), 16'($urandom), $urandom);
    test_random_sessions(300);

    // back-to-back transactions with no idling on either side
    wait_for_results();
    idle_on = 1'b0;
    program_regs(16'($urandom), 16'($urandom), $urandom);
    test_random_sessions(400);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/bgpfsm_pkg.sv
hdl/bgpfsm_cfg_regs.sv
hdl/bgpfsm_session.sv
hdl/bgp_peer_session_fsm_top.sv
hdl/bgpfsm_checker.sv
test/tb_top.sv
